// ===== design/rtks_pkg.sv =====
package rtks_pkg;

  typedef enum logic [2:0] {
    OpAppend    = 3'd0,
    OpUpdate    = 3'd1,
    OpFind      = 3'd2,
    OpDelete    = 3'd3,
    OpSortName  = 3'd4,
    OpSortField = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    StatDone     = 2'd0,
    StatNotFound = 2'd1,
    StatFull     = 2'd2,
    StatEmpty    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    StIdle,
    StDispatch,
    StSearch,
    StShift,
    StSortLoad,
    StSortWait,
    StSortScan,
    StEmitRd,
    StEmitWr,
    StResp
  } state_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] id_key;
    logic [63:0] surname_key;
    logic [63:0] given_key;
    logic [63:0] field_key;
    logic [7:0]  tag;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_tag;
    logic [5:0] position;
    logic [6:0] entry_count;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [63:0] id_key;
    logic [63:0] surname_key;
    logic [63:0] given_key;
    logic [63:0] field_key;
    logic [7:0]  tag;
  } rec_t;

  // True when record a must be placed after record b.
  function automatic logic rec_gt(rec_t a, rec_t b, logic by_field);
    logic res;
    if (by_field) begin
      res = {a.field_key, a.surname_key, a.given_key} >
            {b.field_key, b.surname_key, b.given_key};
    end else begin
      res = {a.surname_key, a.given_key} > {b.surname_key, b.given_key};
    end
    return res;
  endfunction

endpackage

// ===== design/rtks_mem.sv =====
module rtks_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                clk_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  rtks_pkg::rec_t      wdata_i,
  output rtks_pkg::rec_t      rdata_o
);

  rtks_pkg::rec_t mem [DEPTH];
  rtks_pkg::rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/record_table_key_sort_top.sv =====
// Record table with id search, delete with compaction and exchange sort.
// One input channel (in_valid_i/in_ready_o/in_data_i) takes operations; one
// output channel (out_valid_o/out_ready_i/out_data_o) returns results.
// The block works on one operation at a time; in_ready_o is high only while
// it is idle, and it can take the next operation while the last result still
// waits in the output register.
// Append writes the record in the dispatch state and presents its result through
// the response state. Update, find and delete walk the table one entry per cycle
// through the record memory read port; delete first moves every later entry
// down, one per cycle, before its result.
// A sort loads entry i, then compares it with every later entry at one
// compare per cycle, followed by N results for N records, each read from
// the memory and then registered for output. The single record memory port
// pair sets this pace.
// Reset clears the record count and the control state; the memory needs no
// clearing since entries beyond the count are never read.
// When the receiver stalls, the result holds in the output register and the
// block waits before producing the next one.
module record_table_key_sort_top #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned KEY_CHARS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rtks_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rtks_pkg::out_t out_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [63:0] KeyMask = {64{1'b1}} << (8 * (8 - KEY_CHARS));
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  rtks_pkg::state_e state_q, state_d;
  rtks_pkg::in_t    in_q, in_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic             pv_q, pv_d;
  logic [AW-1:0]    paddr_q, paddr_d;
  rtks_pkg::rec_t   acc_q, acc_d;
  rtks_pkg::out_t   res_q, res_d;
  rtks_pkg::out_t   out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             re, we;
  logic [AW-1:0]    raddr, waddr;
  rtks_pkg::rec_t   wdata, rdata;

  logic             hit, scan_more, scan_done, out_free, gt, sort_done, emit_last;
  logic [CW-1:0]    idx_w;

  rtks_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (re),
    .raddr_i (raddr),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign idx_w     = CW'(idx_q);
  assign hit       = pv_q && (rdata.id_key == in_q.id_key);
  assign scan_more = ptr_q < cnt_q;
  assign scan_done = !scan_more && !pv_q;
  assign out_free  = !out_valid_q || out_ready_i;
  assign gt        = rtks_pkg::rec_gt(acc_q, rdata, in_q.op == rtks_pkg::OpSortField);
  assign sort_done = (idx_w + CW'(1)) >= cnt_q;
  assign emit_last = (ptr_q + CW'(1)) == cnt_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rtks_pkg::StIdle: begin
        if (in_valid_i) state_d = rtks_pkg::StDispatch;
      end
      rtks_pkg::StDispatch: begin
        unique case (in_q.op)
          rtks_pkg::OpAppend: state_d = rtks_pkg::StResp;
          rtks_pkg::OpUpdate, rtks_pkg::OpFind, rtks_pkg::OpDelete:
            state_d = rtks_pkg::StSearch;
          rtks_pkg::OpSortName, rtks_pkg::OpSortField:
            state_d = (cnt_q == '0) ? rtks_pkg::StResp : rtks_pkg::StSortLoad;
          default: state_d = rtks_pkg::StIdle;
        endcase
      end
      rtks_pkg::StSearch: begin
        if (hit) begin
          state_d = (in_q.op == rtks_pkg::OpDelete) ? rtks_pkg::StShift : rtks_pkg::StResp;
        end else if (scan_done) begin
          state_d = rtks_pkg::StResp;
        end
      end
      rtks_pkg::StShift: begin
        if (scan_done) state_d = rtks_pkg::StResp;
      end
      rtks_pkg::StSortLoad: begin
        state_d = sort_done ? rtks_pkg::StEmitRd : rtks_pkg::StSortWait;
      end
      rtks_pkg::StSortWait: state_d = rtks_pkg::StSortScan;
      rtks_pkg::StSortScan: begin
        if (scan_done) state_d = rtks_pkg::StSortLoad;
      end
      rtks_pkg::StEmitRd: state_d = rtks_pkg::StEmitWr;
      rtks_pkg::StEmitWr: begin
        if (out_free) state_d = emit_last ? rtks_pkg::StIdle : rtks_pkg::StEmitRd;
      end
      rtks_pkg::StResp: begin
        if (out_free) state_d = rtks_pkg::StIdle;
      end
      default: state_d = rtks_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_d        = in_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    pv_d        = 1'b0;
    paddr_d     = paddr_q;
    acc_d       = acc_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    re          = 1'b0;
    raddr       = ptr_q[AW-1:0];
    we          = 1'b0;
    waddr       = paddr_q;
    wdata       = acc_q;

    unique case (state_q)
      rtks_pkg::StIdle: begin
        in_d.op          = in_data_i.op;
        in_d.id_key      = in_data_i.id_key & KeyMask;
        in_d.surname_key = in_data_i.surname_key & KeyMask;
        in_d.given_key   = in_data_i.given_key & KeyMask;
        in_d.field_key   = in_data_i.field_key & KeyMask;
        in_d.tag         = in_data_i.tag;
      end
      rtks_pkg::StDispatch: begin
        ptr_d = '0;
        idx_d = '0;
        res_d = '{status: rtks_pkg::StatNotFound, out_tag: '0, position: '0,
                  entry_count: '0, last: 1'b1};
        unique case (in_q.op)
          rtks_pkg::OpAppend: begin
            if (cnt_q >= DepthC) begin
              res_d.status = rtks_pkg::StatFull;
            end else begin
              we     = 1'b1;
              waddr  = cnt_q[AW-1:0];
              wdata  = '{id_key: in_q.id_key, surname_key: in_q.surname_key,
                         given_key: in_q.given_key, field_key: in_q.field_key,
                         tag: in_q.tag};
              cnt_d  = cnt_q + CW'(1);
              res_d.status   = rtks_pkg::StatDone;
              res_d.out_tag  = in_q.tag;
              res_d.position = 6'(cnt_q[AW-1:0]);
            end
          end
          rtks_pkg::OpSortName, rtks_pkg::OpSortField: res_d.status = rtks_pkg::StatEmpty;
          default: ;
        endcase
      end
      rtks_pkg::StSearch, rtks_pkg::StShift, rtks_pkg::StSortScan: begin
        if (scan_more) begin
          re      = 1'b1;
          raddr   = ptr_q[AW-1:0];
          pv_d    = 1'b1;
          paddr_d = ptr_q[AW-1:0];
          ptr_d   = ptr_q + CW'(1);
        end
        if (state_q == rtks_pkg::StSearch && hit) begin
          idx_d          = paddr_q;
          ptr_d          = CW'(paddr_q) + CW'(1);
          pv_d           = 1'b0;
          res_d.status   = rtks_pkg::StatDone;
          res_d.out_tag  = rdata.tag;
          res_d.position = 6'(paddr_q);
          if (in_q.op == rtks_pkg::OpUpdate) begin
            we    = 1'b1;
            waddr = paddr_q;
            wdata = '{id_key: rdata.id_key, surname_key: in_q.surname_key,
                      given_key: in_q.given_key, field_key: in_q.field_key,
                      tag: in_q.tag};
            res_d.out_tag = in_q.tag;
          end
        end
        if (state_q == rtks_pkg::StShift) begin
          if (pv_q) begin
            we    = 1'b1;
            waddr = paddr_q - AW'(1);
            wdata = rdata;
          end
          if (scan_done) cnt_d = cnt_q - CW'(1);
        end
        if (state_q == rtks_pkg::StSortScan) begin
          if (pv_q && gt) begin
            we    = 1'b1;
            waddr = paddr_q;
            wdata = acc_q;
            acc_d = rdata;
          end
          if (scan_done) begin
            we    = 1'b1;
            waddr = idx_q;
            wdata = acc_q;
            idx_d = idx_q + AW'(1);
          end
        end
      end
      rtks_pkg::StSortLoad: begin
        re    = !sort_done;
        raddr = idx_q;
        ptr_d = '0;
      end
      rtks_pkg::StSortWait: begin
        acc_d = rdata;
        ptr_d = idx_w + CW'(1);
      end
      rtks_pkg::StEmitRd: begin
        re    = 1'b1;
        raddr = ptr_q[AW-1:0];
      end
      rtks_pkg::StEmitWr: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{status: rtks_pkg::StatDone, out_tag: rdata.tag,
                    position: 6'(ptr_q[AW-1:0]), entry_count: 7'(cnt_q),
                    last: emit_last};
          ptr_d = ptr_q + CW'(1);
        end
      end
      rtks_pkg::StResp: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d             = res_q;
          out_d.entry_count = 7'(cnt_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtks_pkg::StIdle;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    idx_q   <= idx_d;
    ptr_q   <= ptr_d;
    paddr_q <= paddr_d;
    acc_q   <= acc_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign in_ready_o  = state_q == rtks_pkg::StIdle;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC)
    else $error("Record count exceeds the table depth.");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (re && we) |-> (raddr != waddr))
    else $error("Read and write hit the same entry in one cycle.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("A new operation was taken while one is in progress.");

endmodule
